/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/rptc_pkg.sv */
`default_nettype none

package rptc_pkg;

  // Pixel and accumulator formats
  localparam int FRAC_BITS = 8;
  localparam int PIX_W     = 8;
  localparam int ACC_W     = PIX_W + FRAC_BITS;
  localparam int POS_W     = 21;
  localparam int ADDR_W    = 21;
  localparam int PIXELS    = 2 ** ADDR_W;
  localparam int CHANNELS  = 3;

  // Configuration register widths
  localparam int MODE_W     = 2;
  localparam int DECAY_W    = 16;
  localparam int BLEND_W    = 16;
  localparam int GROWTH_W   = 18;
  localparam int CEIL_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL   = 3'd4;

  // Compositing modes
  localparam logic [MODE_W-1:0] MODE_DECAY_MAX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLEND     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRAIL     = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_DECAY_MAX;
  localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd62259;
  localparam logic [BLEND_W-1:0]  BLEND_RST  = 16'd3277;
  localparam logic [GROWTH_W-1:0] GROWTH_RST = 18'd65601;
  localparam logic [CEIL_W-1:0]   CEIL_RST   = 24'd718080;

  // Datapath widths of the Q16 products
  localparam int Q_SHIFT = 16;
  localparam int OPA_W   = ((CEIL_W > ACC_W) ? CEIL_W : ACC_W) + 1;
  localparam int OPB_W   = ((GROWTH_W > BLEND_W + 1) ? GROWTH_W : BLEND_W + 1) + 1;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int XW_W    = ACC_W + BLEND_W;
  localparam int SUM_W   = ((CEIL_W + Q_SHIFT > PROD_W) ? CEIL_W + Q_SHIFT : PROD_W) + 2;

  localparam logic [BLEND_W:0]          ONE_Q16   = (BLEND_W + 1)'(1) << Q_SHIFT;
  localparam logic signed [SUM_W-1:0]   HALF_Q16  = SUM_W'(1) << (Q_SHIFT - 1);
  localparam logic signed [SUM_W-1:0]   ACC_MAX_S = (SUM_W'(1) << ACC_W) - SUM_W'(1);
  localparam logic [ACC_W:0]            PIX_HALF  = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W:0]            PIX_MAX   = (ACC_W + 1)'((1 << PIX_W) - 1);

  // Result queue default depth
  localparam int OQ_DEPTH_DEF = 8;

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CHANNELS-1:0][ACC_W-1:0] acc_vec_t;
  typedef logic [CHANNELS-1:0][PIX_W-1:0] pix_vec_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    pix_vec_t         pix;
  } res_t;

  // Clamp a signed Q16-shifted value to the accumulator range
  function automatic acc_t sat_acc(input logic signed [SUM_W-1:0] q);
    acc_t r;
    if (q < 0) begin
      r = '0;
    end else if (q > ACC_MAX_S) begin
      r = '1;
    end else begin
      r = q[ACC_W-1:0];
    end
    return r;
  endfunction

  // Round an accumulator channel to the nearest pixel value and clamp to 255
  function automatic pix_t to_pixel(input acc_t a);
    logic [ACC_W:0] r;
    r = ({1'b0, a} + PIX_HALF) >> FRAC_BITS;
    if (r > PIX_MAX) begin
      r = PIX_MAX;
    end
    return r[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/rptc_in_if.sv */
`default_nettype none

interface rptc_in_if;
  import rptc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_index;
  logic             first_frame;
  pix_t             blue_in;
  pix_t             green_in;
  pix_t             red_in;

  modport source (
    output valid, pixel_index, first_frame, blue_in, green_in, red_in,
    input  ready
  );

  modport sink (
    input  valid, pixel_index, first_frame, blue_in, green_in, red_in,
    output ready
  );
endinterface

`default_nettype wire

/* src/rptc_out_if.sv */
`default_nettype none

interface rptc_out_if;
  import rptc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_position;
  pix_t             blue_out;
  pix_t             green_out;
  pix_t             red_out;

  modport source (
    output valid, pixel_position, blue_out, green_out, red_out,
    input  ready
  );

  modport sink (
    input  valid, pixel_position, blue_out, green_out, red_out,
    output ready
  );
endinterface

`default_nettype wire

/* src/recursive_pixel_trail_compositor.sv */
// A result passes the stage 1, stage 2 and stage 3 registers and the result queue before it is offered.
// Throughput: one pixel per cycle while the result queue has room; a pixel at the same position as the one
// accepted in the cycle before waits until that one has left stage 1 for the accumulator read-modify-write.
// A result queue of OQ_DEPTH entries keeps input open while results wait.
// Reset (rst_n, synchronous) clears control and loads register defaults;
// the accumulator memory is not cleared and is filled by first-frame pixels.
`default_nettype none

module recursive_pixel_trail_compositor #(
  parameter int OQ_DEPTH = rptc_pkg::OQ_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rptc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rptc_in_if.sink                          in_req,
  rptc_out_if.source                       out_res
);
  import rptc_pkg::*;

  localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int OCC_W = CNT_W + 2;

  // Configuration registers
  logic [MODE_W-1:0]   mode_r;
  logic [DECAY_W-1:0]  decay_r;
  logic [BLEND_W-1:0]  blend_r;
  logic [GROWTH_W-1:0] growth_r;
  logic [CEIL_W-1:0]   ceil_r;

  // Input side
  logic              in_hazard;
  logic              in_room;
  logic              in_acc;
  logic [ADDR_W-1:0] in_addr;
  logic [OCC_W-1:0]  occ;

  // Accumulator memory
  acc_vec_t acc_mem [PIXELS];
  acc_vec_t rd_data_r;

  // Stage 1: read data and multiply
  logic                       s1_valid_r;
  logic [POS_W-1:0]           s1_pos_r;
  logic                       s1_first_r;
  pix_vec_t                   s1_pix_r;
  acc_vec_t                   s1_acc;
  logic                       s1_fwd;
  acc_t                       s1_xs   [CHANNELS];
  logic signed [OPA_W-1:0]    s1_opa  [CHANNELS];
  logic signed [OPB_W-1:0]    s1_opb  [CHANNELS];
  logic signed [PROD_W-1:0]   s1_m1   [CHANNELS];
  logic [XW_W-1:0]            s1_m2   [CHANNELS];

  // Stage 2: sum, round, clamp, write back
  logic                       s2_valid_r;
  logic [POS_W-1:0]           s2_pos_r;
  logic                       s2_first_r;
  acc_vec_t                   s2_acc_r;
  acc_t                       s2_xs_r [CHANNELS];
  logic signed [PROD_W-1:0]   s2_m1_r [CHANNELS];
  logic [XW_W-1:0]            s2_m2_r [CHANNELS];
  logic signed [SUM_W-1:0]    s2_sum  [CHANNELS];
  acc_t                       s2_sat  [CHANNELS];
  acc_vec_t                   s2_acc_nxt;

  // Stage 3: written-back value, pixel conversion
  logic             s3_valid_r;
  logic [POS_W-1:0] s3_pos_r;
  acc_vec_t         s3_acc_r;
  res_t             s3_res;

  // Result queue
  res_t             oq_r [OQ_DEPTH];
  logic [PTR_W-1:0] oq_wr_ptr_r;
  logic [PTR_W-1:0] oq_rd_ptr_r;
  logic [CNT_W-1:0] oq_cnt_r;
  logic             oq_push;
  logic             oq_pop;
  res_t             oq_head;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      decay_r  <= DECAY_RST;
      blend_r  <= BLEND_RST;
      growth_r <= GROWTH_RST;
      ceil_r   <= CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_DECAY:  decay_r  <= cfg_wdata[DECAY_W-1:0];
        REG_BLEND:  blend_r  <= cfg_wdata[BLEND_W-1:0];
        REG_GROWTH: growth_r <= cfg_wdata[GROWTH_W-1:0];
        REG_CEIL:   ceil_r   <= cfg_wdata[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Admit a request when the queue has room for everything in flight and
  // the position does not collide with the one still being read
  assign in_addr   = in_req.pixel_index[ADDR_W-1:0];
  assign in_hazard = s1_valid_r && (s1_pos_r[ADDR_W-1:0] == in_addr);
  assign occ       = OCC_W'(oq_cnt_r) + OCC_W'(s1_valid_r) + OCC_W'(s2_valid_r)
                   + OCC_W'(s3_valid_r);
  assign in_room   = occ < OCC_W'(OQ_DEPTH);
  assign in_req.ready = in_room && !in_hazard;
  assign in_acc    = in_req.valid && in_req.ready;

  // Read on accept, write back from stage 2
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= acc_mem[in_addr];
    end
    if (s2_valid_r) begin
      acc_mem[s2_pos_r[ADDR_W-1:0]] <= s2_acc_nxt;
    end
  end

  // Forward the value written at the same edge as this read
  assign s1_fwd = s3_valid_r && (s3_pos_r[ADDR_W-1:0] == s1_pos_r[ADDR_W-1:0]);
  assign s1_acc = s1_fwd ? s3_acc_r : rd_data_r;

  // Select multiplier operands per mode and multiply
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      s1_xs[c] = ACC_W'(s1_pix_r[c]) << FRAC_BITS;
      case (mode_r)
        MODE_TRAIL: begin
          s1_opa[c] = signed'(OPA_W'(ceil_r)) - signed'(OPA_W'(s1_acc[c]));
          s1_opb[c] = signed'(OPB_W'(growth_r));
        end
        MODE_BLEND: begin
          s1_opa[c] = signed'(OPA_W'(s1_acc[c]));
          s1_opb[c] = signed'(OPB_W'(ONE_Q16 - {1'b0, blend_r}));
        end
        default: begin
          s1_opa[c] = signed'(OPA_W'(s1_acc[c]));
          s1_opb[c] = signed'(OPB_W'(decay_r));
        end
      endcase
      s1_m1[c] = s1_opa[c] * s1_opb[c];
      s1_m2[c] = XW_W'(s1_xs[c]) * XW_W'(blend_r);
    end
  end

  // Round the products, clamp, and pick the new accumulator
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      case (mode_r)
        MODE_TRAIL:
          s2_sum[c] = (signed'(SUM_W'(ceil_r)) <<< Q_SHIFT) - SUM_W'(s2_m1_r[c]) + HALF_Q16;
        MODE_BLEND:
          s2_sum[c] = SUM_W'(s2_m1_r[c]) + signed'(SUM_W'(s2_m2_r[c])) + HALF_Q16;
        default:
          s2_sum[c] = SUM_W'(s2_m1_r[c]) + HALF_Q16;
      endcase
      s2_sat[c] = sat_acc(s2_sum[c] >>> Q_SHIFT);
      if (s2_first_r) begin
        s2_acc_nxt[c] = s2_xs_r[c];
      end else begin
        case (mode_r) inside
          MODE_DECAY_MAX, MODE_TRAIL:
            s2_acc_nxt[c] = (s2_sat[c] > s2_xs_r[c]) ? s2_sat[c] : s2_xs_r[c];
          MODE_BLEND:
            s2_acc_nxt[c] = s2_sat[c];
          default:
            s2_acc_nxt[c] = s2_acc_r[c];
        endcase
      end
    end
  end

  // Convert the written-back value to a result
  always_comb begin
    s3_res.pos = s3_pos_r;
    for (int c = 0; c < CHANNELS; c++) begin
      s3_res.pix[c] = to_pixel(s3_acc_r[c]);
    end
  end

  // Advance pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    s1_pos_r    <= in_req.pixel_index;
    s1_first_r  <= in_req.first_frame;
    s1_pix_r[0] <= in_req.blue_in;
    s1_pix_r[1] <= in_req.green_in;
    s1_pix_r[2] <= in_req.red_in;
    s2_pos_r    <= s1_pos_r;
    s2_first_r  <= s1_first_r;
    s2_acc_r    <= s1_acc;
    for (int c = 0; c < CHANNELS; c++) begin
      s2_xs_r[c] <= s1_xs[c];
      s2_m1_r[c] <= s1_m1[c];
      s2_m2_r[c] <= s1_m2[c];
    end
    s3_pos_r    <= s2_pos_r;
    s3_acc_r    <= s2_acc_nxt;
  end

  // Result queue: push from stage 3, pop on the output handshake
  assign oq_push = s3_valid_r;
  assign oq_pop  = out_res.valid && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_ptr_r <= (oq_wr_ptr_r == PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_ptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_ptr_r <= (oq_rd_ptr_r == PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_ptr_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + CNT_W'(oq_push) - CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_ptr_r] <= s3_res;
    end
  end

  // Drive the result channel from the queue head
  assign oq_head                = oq_r[oq_rd_ptr_r];
  assign out_res.valid          = (oq_cnt_r != '0);
  assign out_res.pixel_position = oq_head.pos;
  assign out_res.blue_out       = oq_head.pix[0];
  assign out_res.green_out      = oq_head.pix[1];
  assign out_res.red_out        = oq_head.pix[2];

`include "assert_macros.svh"

  `ASSERT_NEVER(a_no_rmw_overlap, s1_valid_r && s2_valid_r && (s1_pos_r[ADDR_W-1:0] == s2_pos_r[ADDR_W-1:0]), "two requests to one position overlap in read-modify-write")
  `ASSERT_NEVER(a_oq_no_overflow, occ > OCC_W'(OQ_DEPTH), "results in flight exceed queue depth")
  `ASSERT_CLK(a_accept_reaches_s1, in_acc |=> s1_valid_r && (s1_pos_r == $past(in_req.pixel_index)), "accepted request lost before stage 1")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rptc_pkg::*;

  // Mode code left unused by the block: the accumulator is held as it is
  localparam logic [MODE_W-1:0] MODE_HOLD      = 2'd3;
  localparam int                WATCHDOG_LIMIT = 4000;
  localparam int                PRESSURE_HOLD  = 300;
  localparam int                TAIL_CYCLES    = 8;
  localparam int                PRINT_LIMIT    = 40;
  localparam logic [63:0]       CHAN_MAX       = (64'd1 << ACC_W) - 64'd1;
  localparam logic [63:0]       Q16_ONE        = 64'd1 << Q_SHIFT;
  localparam logic [63:0]       Q16_HALF       = 64'd1 << (Q_SHIFT - 1);
  localparam int unsigned       POS_LAST       = PIXELS - 1;

  typedef struct {
    logic [POS_W-1:0] pos;
    logic             first;
    pix_t             blue;
    pix_t             green;
    pix_t             red;
  } pixel_req_t;

  typedef struct {
    logic [POS_W-1:0] pos;
    pix_t             blue;
    pix_t             green;
    pix_t             red;
  } pixel_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rptc_in_if  in_if();
  rptc_out_if out_if();

  recursive_pixel_trail_compositor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_if),
    .out_res   (out_if)
  );

  // Shadow copy of the register file and of the accumulator frame
  logic [MODE_W-1:0]   mode_q    = MODE_RST;
  logic [DECAY_W-1:0]  decay_q   = DECAY_RST;
  logic [BLEND_W-1:0]  blend_q   = BLEND_RST;
  logic [GROWTH_W-1:0] growth_q  = GROWTH_RST;
  logic [CEIL_W-1:0]   ceiling_q = CEIL_RST;
  acc_vec_t            trail_frame [int unsigned];

  pixel_res_t  pending_pixels [$];
  int unsigned seeded_list [$];
  bit          is_seeded [int unsigned];

  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a widened channel value to the accumulator range
  function automatic acc_t clamp_channel(logic [63:0] v);
    return (v > CHAN_MAX) ? '1 : v[ACC_W-1:0];
  endfunction

  function automatic pix_t round_to_pixel(acc_t a);
    int unsigned r;
    r = a;
    r = (r + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (r > (1 << PIX_W) - 1) ? '1 : PIX_W'(r);
  endfunction

  // Advance one accumulator channel by the selected mode
  function automatic acc_t next_channel(acc_t acc, pix_t x);
    logic [63:0]        a;
    logic [63:0]        xs;
    logic [63:0]        sum;
    logic signed [63:0] diff;
    logic signed [63:0] t;
    acc_t               kept;
    acc_t               scaled;
    a      = 64'(acc);
    xs     = 64'(x) << FRAC_BITS;
    scaled = xs[ACC_W-1:0];
    case (mode_q)
      MODE_DECAY_MAX: begin
        kept = clamp_channel((a * decay_q + Q16_HALF) >> Q_SHIFT);
        if (scaled > kept) begin
          kept = scaled;
        end
      end
      MODE_BLEND: begin
        sum  = a * (Q16_ONE - 64'(blend_q)) + xs * 64'(blend_q) + Q16_HALF;
        kept = clamp_channel(sum >> Q_SHIFT);
      end
      MODE_TRAIL: begin
        diff = $signed(64'(ceiling_q)) - $signed(a);
        t    = $signed(64'(ceiling_q) << Q_SHIFT) - diff * $signed(64'(growth_q));
        kept = (t > 0) ? clamp_channel(($unsigned(t) + Q16_HALF) >> Q_SHIFT) : '0;
        if (scaled > kept) begin
          kept = scaled;
        end
      end
      default: begin
        kept = acc;
      end
    endcase
    return kept;
  endfunction

  // Update the shadow frame with one accepted request and return its pixel
  function automatic pixel_res_t compose_pixel(pixel_req_t rq);
    pixel_res_t res;
    acc_vec_t   acc;
    pix_vec_t   px;
    int         c;
    px  = {rq.red, rq.green, rq.blue};
    acc = '0;
    if (!rq.first) begin
      acc = trail_frame[rq.pos];
    end
    for (c = 0; c < CHANNELS; c++) begin
      acc[c] = rq.first ? (acc_t'(px[c]) << FRAC_BITS) : next_channel(acc[c], px[c]);
    end
    trail_frame[rq.pos] = acc;
    res.pos   = rq.pos;
    res.blue  = round_to_pixel(acc[0]);
    res.green = round_to_pixel(acc[1]);
    res.red   = round_to_pixel(acc[2]);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Drop the request and hold until every pending pixel has come back
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_MODE:   mode_q    = data[MODE_W-1:0];
      REG_DECAY:  decay_q   = data[DECAY_W-1:0];
      REG_BLEND:  blend_q   = data[BLEND_W-1:0];
      REG_GROWTH: growth_q  = data[GROWTH_W-1:0];
      REG_CEIL:   ceiling_q = data[CEIL_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one request, idling first at the current gap rate
  task automatic send_pixel(pixel_req_t rq);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.pixel_index = rq.pos;
    in_if.first_frame = rq.first;
    in_if.blue_in     = rq.blue;
    in_if.green_in    = rq.green;
    in_if.red_in      = rq.red;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    pending_pixels.push_back(compose_pixel(rq));
  endtask

  task automatic send_rgb(int unsigned pos, bit first, pix_t b, pix_t g, pix_t r);
    pixel_req_t rq;
    rq.pos   = POS_W'(pos);
    rq.first = first;
    rq.blue  = b;
    rq.green = g;
    rq.red   = r;
    if (first && !is_seeded.exists(pos)) begin
      is_seeded[pos] = 1'b1;
      seeded_list.push_back(pos);
    end
    send_pixel(rq);
  endtask

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_position();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return POS_LAST;
      default: return $urandom_range(0, POS_LAST);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_setting(int unsigned lo, int unsigned hi,
                                                         int unsigned near_lo,
                                                         int unsigned near_hi);
    case ($urandom_range(0, 5))
      0: return CFG_DATA_W'(lo);
      1: return CFG_DATA_W'(hi);
      2, 3: return CFG_DATA_W'($urandom_range(near_lo, near_hi));
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic send_at(int unsigned pos, bit first);
    send_rgb(pos, first, pick_pixel(), pick_pixel(), pick_pixel());
  endtask

  task automatic shuffle_registers();
    logic [MODE_W-1:0] m;
    m = ($urandom_range(0, 7) == 0) ? MODE_HOLD : MODE_W'($urandom_range(0, 2));
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_DECAY, pick_setting(0, 65535, 58000, 65535));
    write_reg(REG_BLEND, pick_setting(0, 65535, 0, 8000));
    write_reg(REG_GROWTH, pick_setting(65536, 262143, 65536, 66500));
    write_reg(REG_CEIL, pick_setting(0, 24'hFFFFFF, 65280, 800000));
  endtask

  // Short frames: seed a run of positions, then update them over several passes
  task automatic run_frames(int items);
    int unsigned frame_pos [$];
    int unsigned p;
    int          sent;
    sent = 0;
    while (sent < items) begin
      frame_pos.delete();
      p = pick_position();
      repeat ($urandom_range(1, 10)) begin
        frame_pos.push_back(p);
        // mostly raster neighbors, a jump now and then
        p = ($urandom_range(0, 3) == 0) ? pick_position() : (p + 1) % PIXELS;
      end
      foreach (frame_pos[i]) begin
        send_at(frame_pos[i], 1'b1);
        sent++;
      end
      repeat ($urandom_range(1, 6)) begin
        foreach (frame_pos[i]) begin
          case ($urandom_range(0, 9))
            0: begin
              // same position back to back hits the read-modify-write hazard
              send_at(frame_pos[i], 1'b0);
              send_at(frame_pos[i], 1'b0);
              sent += 2;
            end
            1: begin
              send_at(seeded_list[$urandom_range(0, seeded_list.size() - 1)], 1'b0);
              sent++;
            end
            2: begin
              send_at(frame_pos[i], 1'b1);
              sent++;
            end
            default: begin
              send_at(frame_pos[i], 1'b0);
              sent++;
            end
          endcase
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    int k;
    gap_pct   = 0;
    stall_pct = 0;
    // Seed the extreme and alternating positions under reset defaults
    send_rgb(0, 1'b1, 8'd0, 8'd255, 8'd128);
    send_rgb(POS_LAST, 1'b1, 8'd255, 8'd0, 8'd1);
    send_rgb(21'h0AAAAA, 1'b1, 8'd127, 8'd128, 8'd255);
    send_rgb(21'h155555, 1'b1, 8'd200, 8'd50, 8'd0);
    // Decayed max, including a repeat at the same position
    send_rgb(0, 1'b0, 8'd0, 8'd0, 8'd0);
    send_rgb(0, 1'b0, 8'd0, 8'd0, 8'd0);
    send_rgb(POS_LAST, 1'b0, 8'd255, 8'd255, 8'd255);
    write_reg(REG_DECAY, '0);
    send_rgb(21'h0AAAAA, 1'b0, 8'd10, 8'd0, 8'd0);
    write_reg(REG_DECAY, 24'd65535);
    send_rgb(POS_LAST, 1'b0, 8'd0, 8'd0, 8'd0);
    // Exponential blend at both weight extremes
    write_reg(REG_MODE, CFG_DATA_W'(MODE_BLEND));
    write_reg(REG_BLEND, 24'd65535);
    send_rgb(0, 1'b0, 8'd255, 8'd255, 8'd255);
    write_reg(REG_BLEND, '0);
    send_rgb(0, 1'b0, 8'd0, 8'd0, 8'd0);
    // Trail with the accumulator above a zero ceiling saturates
    write_reg(REG_MODE, CFG_DATA_W'(MODE_TRAIL));
    write_reg(REG_CEIL, '0);
    write_reg(REG_GROWTH, 24'd262143);
    send_rgb(POS_LAST, 1'b0, 8'd0, 8'd0, 8'd0);
    // Highest ceiling drives the trail term negative; floor at zero
    write_reg(REG_CEIL, 24'hFFFFFF);
    send_rgb(0, 1'b0, 8'd0, 8'd200, 8'd255);
    write_reg(REG_GROWTH, 24'd65536);
    send_rgb(0, 1'b0, 8'd1, 8'd0, 8'd0);
    // Growth below one
    write_reg(REG_CEIL, CFG_DATA_W'(CEIL_RST));
    write_reg(REG_GROWTH, 24'd1000);
    send_rgb(21'h155555, 1'b0, 8'd0, 8'd0, 8'd0);
    send_rgb(21'h155555, 1'b0, 8'd0, 8'd0, 8'd0);
    // Unused mode code holds the accumulator
    write_reg(REG_MODE, CFG_DATA_W'(MODE_HOLD));
    send_rgb(21'h155555, 1'b0, 8'd255, 8'd0, 8'd255);
    // Indexes past the register list must change nothing
    for (k = 1; k <= 3; k++) begin
      write_reg(CFG_IDX_W'(REG_CEIL + k), CFG_DATA_W'($urandom));
    end
    send_rgb(21'h0AAAAA, 1'b0, 8'd255, 8'd255, 8'd255);
    send_rgb(0, 1'b1, 8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_random_streams();
    int gaps [4]   = '{0, 49, 0, 9};
    int stalls [4] = '{0, 0, 49, 9};
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      gap_pct   = gaps[ph];
      stall_pct = stalls[ph];
      repeat (6) begin
        shuffle_registers();
        run_frames(60);
      end
    end
  endtask

  // Keep offering requests while the result side is held off
  task automatic test_input_backpressure();
    int unsigned spots [$];
    gap_pct   = 0;
    stall_pct = 0;
    repeat (8) begin
      spots.push_back(pick_position());
    end
    wait_idle();
    hold_left = PRESSURE_HOLD;
    foreach (spots[i]) begin
      send_at(spots[i], 1'b1);
    end
    repeat (4) begin
      foreach (spots[i]) begin
        send_at(spots[i], 1'b0);
      end
    end
  endtask

  // Result-side ready: a long hold when asked, else random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each returned pixel with the oldest pending one
  always @(posedge clk) begin
    pixel_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unrequested pixel, position", out_if.pixel_position, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_if.pixel_position !== want.pos) begin
          report_mismatch("pixel_position", out_if.pixel_position, want.pos);
        end
        if (out_if.blue_out !== want.blue) begin
          report_mismatch("blue_out", out_if.blue_out, want.blue);
        end
        if (out_if.green_out !== want.green) begin
          report_mismatch("green_out", out_if.green_out, want.green);
        end
        if (out_if.red_out !== want.red) begin
          report_mismatch("red_out", out_if.red_out, want.red);
        end
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL recursive_pixel_trail_compositor");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_MODE;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.pixel_index = '0;
    in_if.first_frame = 1'b0;
    in_if.blue_in     = '0;
    in_if.green_in    = '0;
    in_if.red_in      = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_streams();
    test_input_backpressure();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS recursive_pixel_trail_compositor");
    end else begin
      $display("FAIL recursive_pixel_trail_compositor");
    end
    $finish;
  end

endmodule

`default_nettype wire
